// ----- hdl/egbw_pkg.sv -----
// ----------------------------------------------------------------------------
// egbw_pkg: shared types and constants of the Exp-Golomb bit writer
// Request and result payloads, command codes, the queue entry handed from the
// front end to the back end, and the leading-one search used for ue/se codes.
// ----------------------------------------------------------------------------
package egbw_pkg;

  // Command codes carried in a request.
  localparam logic [2:0] CMD_START = 3'd0;
  localparam logic [2:0] CMD_RAW   = 3'd1;
  localparam logic [2:0] CMD_UE    = 3'd2;
  localparam logic [2:0] CMD_SE    = 3'd3;
  localparam logic [2:0] CMD_TRAIL = 3'd4;

  // Value codes that have no valid Exp-Golomb code.
  localparam logic [31:0] UE_BAD = 32'hFFFF_FFFF;
  localparam logic [31:0] SE_BAD = 32'h8000_0000;

  // Largest legal raw bit count.
  localparam logic [5:0] RAW_MAX = 6'd32;

  // Configuration register map (word index) and reset values.
  localparam int         ADDR_W        = 3;
  localparam logic       REG_CAP_BYTES = 1'b0;
  localparam logic [15:0] CAP_RESET    = 16'hFFFF;

  // Default width of the byte counter.
  localparam int COUNT_BITS_DEF = 16;

  // Depth of the queue between front and back end.
  localparam int FIFO_DEPTH = 4;

  // Operation of one queued request, as classified by the front end.
  typedef enum logic [2:0] {
    OP_START,
    OP_WRITE,
    OP_TRAIL,
    OP_FLAG,
    OP_NOP
  } op_t;

  // Queued request: a bit string of n bits, right-aligned in val, with
  // any bits above bit 31 being zero.
  typedef struct packed {
    op_t         op;
    logic [31:0] val;
    logic [5:0]  n;
  } egbw_ent_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] value;
    logic [5:0]  bit_count;
  } egbw_in_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic [15:0] bytes_written;
    logic        overflow;
    logic        last;
  } egbw_out_t;

  // Position of the leading one of a non-zero word, found by halving.
  function automatic logic [4:0] msb_index(input logic [31:0] v);
    logic [4:0]  p;
    logic [15:0] x16;
    logic [7:0]  x8;
    logic [3:0]  x4;
    logic [1:0]  x2;
    p[4] = |v[31:16];
    x16  = p[4] ? v[31:16] : v[15:0];
    p[3] = |x16[15:8];
    x8   = p[3] ? x16[15:8] : x16[7:0];
    p[2] = |x8[7:4];
    x4   = p[2] ? x8[7:4] : x8[3:0];
    p[1] = |x4[3:2];
    x2   = p[1] ? x4[3:2] : x4[1:0];
    p[0] = x2[1];
    return p;
  endfunction

endpackage

// ----- hdl/egbw_front.sv -----
// ----------------------------------------------------------------------------
// egbw_front: request intake and classification
// Accepts requests, checks them for bad codes, maps ue/se values to their
// code word plus one, sizes the bit string and pushes it into the queue.
// ----------------------------------------------------------------------------
module egbw_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  egbw_pkg::egbw_in_t   in_data,
  output logic                 push,
  output egbw_pkg::egbw_ent_t  push_data,
  input  logic                 full
);

  logic                a_valid_r, a_valid_nxt;
  egbw_pkg::op_t       a_op_r, a_op_nxt;
  logic [31:0]         a_val_r, a_val_nxt;
  logic [5:0]          a_n_r, a_n_nxt;
  logic                a_len_r, a_len_nxt;
  logic                accept;

  // Handshake: the stage holds while the queue is full.
  assign in_stall = a_valid_r && full;
  assign accept   = in_valid && !in_stall;
  assign push     = a_valid_r && !full;

  // Classify the request and form the value whose bit length sets the code.
  always_comb begin
    a_op_nxt  = egbw_pkg::OP_NOP;
    a_val_nxt = in_data.value;
    a_n_nxt   = in_data.bit_count;
    a_len_nxt = 1'b0;
    unique case (in_data.cmd)
      egbw_pkg::CMD_START: begin
        a_op_nxt = egbw_pkg::OP_START;
      end
      egbw_pkg::CMD_RAW: begin
        if (in_data.bit_count == 6'd0 || in_data.bit_count > egbw_pkg::RAW_MAX) begin
          a_op_nxt = egbw_pkg::OP_FLAG;
        end else begin
          a_op_nxt = egbw_pkg::OP_WRITE;
        end
      end
      egbw_pkg::CMD_UE: begin
        if (in_data.value == egbw_pkg::UE_BAD) begin
          a_op_nxt = egbw_pkg::OP_FLAG;
        end else begin
          a_op_nxt  = egbw_pkg::OP_WRITE;
          a_val_nxt = in_data.value + 32'd1;
          a_len_nxt = 1'b1;
        end
      end
      egbw_pkg::CMD_SE: begin
        if (in_data.value == egbw_pkg::SE_BAD) begin
          a_op_nxt = egbw_pkg::OP_FLAG;
        end else begin
          a_op_nxt  = egbw_pkg::OP_WRITE;
          a_len_nxt = 1'b1;
          // Zero or negative maps to code -2v, so code plus one is -2v+1.
          if (in_data.value == 32'd0 || in_data.value[31]) begin
            a_val_nxt = ((32'd0 - in_data.value) << 1) | 32'd1;
          end else begin
            a_val_nxt = in_data.value << 1;
          end
        end
      end
      egbw_pkg::CMD_TRAIL: begin
        a_op_nxt = egbw_pkg::OP_TRAIL;
      end
      default: begin
        a_op_nxt = egbw_pkg::OP_NOP;
      end
    endcase
  end

  // Intake stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (accept) begin
      a_valid_r <= 1'b1;
    end else if (push) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_op_r  <= a_op_nxt;
      a_val_r <= a_val_nxt;
      a_n_r   <= a_n_nxt;
      a_len_r <= a_len_nxt;
    end
  end

  // An Exp-Golomb string of a value with leading one at p is 2p+1 bits long.
  always_comb begin
    push_data.op  = a_op_r;
    push_data.val = a_val_r;
    push_data.n   = a_len_r ? {egbw_pkg::msb_index(a_val_r), 1'b1} : a_n_r;
  end

endmodule

// ----- hdl/egbw_fifo.sv -----
// ----------------------------------------------------------------------------
// egbw_fifo: request queue between front and back end
// A short first-in first-out queue of classified requests so that intake and
// bit packing can stall independently.
// ----------------------------------------------------------------------------
module egbw_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  egbw_pkg::egbw_ent_t  push_data,
  output logic                 full,
  input  logic                 pop,
  output logic                 head_valid,
  output egbw_pkg::egbw_ent_t  head
);

  localparam int DEPTH = egbw_pkg::FIFO_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  egbw_pkg::egbw_ent_t ent_r [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;

  assign full       = (cnt_r == CNT_W'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = ent_r[rd_ptr_r];

  // Pointer and fill level update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

  // The front end never pushes into a full queue.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("request queue overrun");

endmodule

// ----- hdl/egbw_back.sv -----
// ----------------------------------------------------------------------------
// egbw_back: bit packer
// Works through the queued requests, packing up to one byte's worth of bits
// per cycle MSB first unless stalled, enforcing the byte capacity and issuing results.
// ----------------------------------------------------------------------------
module egbw_back #(
  parameter int COUNT_BITS = egbw_pkg::COUNT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [15:0]          cap_bytes,
  input  logic                 head_valid,
  input  egbw_pkg::egbw_ent_t  head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output egbw_pkg::egbw_out_t  out_data
);

  // The counter stops at the capacity, which never exceeds 16 bits.
  localparam int          CNT_W   = (COUNT_BITS < 16) ? COUNT_BITS : 16;
  localparam logic [15:0] CNT_MAX = 16'((17'd1 << CNT_W) - 17'd1);

  logic [7:0]        partial_r, partial_nxt;
  logic [2:0]        bp_r, bp_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              ovf_r, ovf_nxt;
  logic              busy_r, busy_nxt;
  logic [5:0]        rem_r, rem_nxt;
  logic              emitted_r, emitted_nxt;
  logic              out_valid_r, out_valid_nxt;
  egbw_pkg::egbw_out_t out_data_r;

  logic [15:0]       limit;
  logic [15:0]       cnt16;
  logic [15:0]       cnt_inc16;
  logic              at_cap;
  logic              step;
  logic [3:0]        room;
  logic [5:0]        rem;
  logic [31:0]       val;
  logic [3:0]        k;
  logic [5:0]        left;
  logic [63:0]       win;
  logic [7:0]        chunk;
  logic [7:0]        placed;
  logic [7:0]        newp;
  logic [3:0]        pos;
  logic              res_v;
  egbw_pkg::egbw_out_t res;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Capacity: the lower of the register and the counter's all-ones value.
  assign limit     = (cap_bytes < CNT_MAX) ? cap_bytes : CNT_MAX;
  assign cnt16     = 16'(cnt_r);
  assign cnt_inc16 = cnt16 + 16'd1;
  assign at_cap    = (cnt16 >= limit);
  assign step      = head_valid && (!out_valid_r || !out_stall);

  // Bits taken this cycle: the rest of the string or the rest of the byte.
  always_comb begin
    room = 4'd8 - {1'b0, bp_r};
    if (head.op == egbw_pkg::OP_TRAIL) begin
      rem = 6'(room);
      val = {24'd0, 8'h80 >> bp_r};
    end else begin
      rem = busy_r ? rem_r : head.n;
      val = head.val;
    end
    k      = (6'(room) < rem) ? room : rem[3:0];
    left   = rem - 6'(k);
    win    = {32'd0, val} >> left;
    chunk  = win[7:0] & 8'((9'd1 << k) - 9'd1);
    placed = chunk << (room - k);
    newp   = partial_r | placed;
    pos    = {1'b0, bp_r} + k;
  end

  // Per-request step and the result it issues.
  always_comb begin
    partial_nxt       = partial_r;
    bp_nxt            = bp_r;
    cnt_nxt           = cnt_r;
    ovf_nxt           = ovf_r;
    busy_nxt          = busy_r;
    rem_nxt           = rem_r;
    emitted_nxt       = emitted_r;
    pop               = 1'b0;
    res_v             = 1'b0;
    res.out_byte      = 8'd0;
    res.byte_valid    = 1'b0;
    res.bytes_written = cnt16;
    res.overflow      = ovf_r;
    res.last          = 1'b1;
    if (step) begin
      unique case (head.op) inside
        egbw_pkg::OP_START: begin
          partial_nxt       = 8'd0;
          bp_nxt            = 3'd0;
          cnt_nxt           = '0;
          ovf_nxt           = 1'b0;
          pop               = 1'b1;
          res_v             = 1'b1;
          res.bytes_written = 16'd0;
          res.overflow      = 1'b0;
        end
        egbw_pkg::OP_FLAG: begin
          ovf_nxt      = 1'b1;
          pop          = 1'b1;
          res_v        = 1'b1;
          res.overflow = 1'b1;
        end
        egbw_pkg::OP_NOP: begin
          pop   = 1'b1;
          res_v = 1'b1;
        end
        egbw_pkg::OP_WRITE, egbw_pkg::OP_TRAIL: begin
          if (at_cap) begin
            // Refused bit: the request ends here with the flag set.
            ovf_nxt     = 1'b1;
            pop         = 1'b1;
            busy_nxt    = 1'b0;
            emitted_nxt = 1'b0;
            if (!emitted_r) begin
              res_v        = 1'b1;
              res.overflow = 1'b1;
            end
          end else begin
            if (pos[3]) begin
              partial_nxt       = 8'd0;
              bp_nxt            = 3'd0;
              cnt_nxt           = cnt_r + {{(CNT_W-1){1'b0}}, 1'b1};
              res_v             = 1'b1;
              res.out_byte      = newp;
              res.byte_valid    = 1'b1;
              res.bytes_written = cnt_inc16;
              // No further byte follows if under eight bits remain or the
              // capacity is now reached.
              res.last          = (left < 6'd8) || (cnt_inc16 >= limit);
            end else begin
              partial_nxt = newp;
              bp_nxt      = pos[2:0];
            end
            if (left == 6'd0) begin
              pop         = 1'b1;
              busy_nxt    = 1'b0;
              emitted_nxt = 1'b0;
              if (!pos[3] && !emitted_r) begin
                res_v = 1'b1;
              end
            end else begin
              busy_nxt    = 1'b1;
              rem_nxt     = left;
              emitted_nxt = emitted_r | pos[3];
            end
          end
        end
        default: begin
          pop   = 1'b1;
          res_v = 1'b1;
        end
      endcase
    end
  end

  // Output register: loads a new result or drains when taken.
  always_comb begin
    if (step && res_v) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r   <= 8'd0;
      bp_r        <= 3'd0;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      busy_r      <= 1'b0;
      rem_r       <= 6'd0;
      emitted_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      partial_r   <= partial_nxt;
      bp_r        <= bp_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      busy_r      <= busy_nxt;
      rem_r       <= rem_nxt;
      emitted_r   <= emitted_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_v) begin
      out_data_r <= res;
    end
  end

  // Each completed byte advances the count by exactly one.
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res_v && res.byte_valid) |=> (16'(cnt_r) == $past(cnt_inc16)))
    else $error("byte count did not advance with a completed byte");

  // A request part-way through packing stays at the queue head.
  a_busy_head: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (head_valid && head.op == egbw_pkg::OP_WRITE))
    else $error("packing in progress without its request at the head");

  // A rejected request leaves the overflow flag set.
  a_flag_sets: assert property (@(posedge clk) disable iff (!rst_n)
    (step && head.op == egbw_pkg::OP_FLAG) |=> ovf_r)
    else $error("overflow flag not set by a rejected request");

  // A status-only result always closes its request.
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.byte_valid) |-> out_data_r.last)
    else $error("status result without last");

endmodule

// ----- hdl/exp_golomb_bit_writer_top.sv -----
// ----------------------------------------------------------------------------
// exp_golomb_bit_writer_top: Exp-Golomb bitstream writer
// A request passes the intake register, the request queue and the output register.
// Throughput: one result per cycle while the output is not stalled; the
// back-end packer, one byte a cycle while not stalled, sets this.
// Reset: synchronous; clears stream state and queue, capacity to 65535.
// ----------------------------------------------------------------------------
module exp_golomb_bit_writer_top #(
  parameter int COUNT_BITS = egbw_pkg::COUNT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  egbw_pkg::egbw_in_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output egbw_pkg::egbw_out_t         out_data,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [egbw_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);

  logic [15:0]          cap_r;
  logic                 cap_sel;
  logic                 cfg_wr;
  logic                 push;
  egbw_pkg::egbw_ent_t  push_data;
  logic                 full;
  logic                 pop;
  logic                 head_valid;
  egbw_pkg::egbw_ent_t  head;

  // Configuration port: single capacity register, no wait states.
  assign cfg_pready = 1'b1;
  assign cap_sel    = (cfg_paddr[egbw_pkg::ADDR_W-1:2] == egbw_pkg::REG_CAP_BYTES);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cap_sel;
  assign cfg_prdata = cap_sel ? {16'd0, cap_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= egbw_pkg::CAP_RESET;
    end else if (cfg_wr) begin
      cap_r <= cfg_pwdata[15:0];
    end
  end

  egbw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  egbw_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  egbw_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cap_bytes  (cap_r),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
